/* src/sfd_pkg.sv */
// Shared types and constants for the SLIP frame decoder.
// No dependencies; used by the front, queue, back and top-level modules of the block.
package sfd_pkg;

    localparam logic [7:0] CODE_FEND  = 8'hC0;
    localparam logic [7:0] CODE_FESC  = 8'hDB;
    localparam logic [7:0] CODE_TFEND = 8'hDC;
    localparam logic [7:0] CODE_TFESC = 8'hDD;

    localparam int MaxPacketDefault = 2048;
    localparam int HardLimit        = 4095;

    localparam logic [11:0] MAX_LENGTH_RESET = 12'd1006;
    localparam logic [3:0]  EXP_VER_RESET    = 4'd4;

    // register indexes on the configuration port
    localparam logic REG_MAX_LENGTH = 1'b0;
    localparam logic REG_EXP_VER    = 1'b1;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    // one classified operation handed from front to back
    typedef struct packed {
        logic       close;
        logic [7:0] data;
    } t_op;

endpackage

/* src/sfd_front.sv */
// Front end: accepts raw bytes, tracks framing and escape state, emits ops.
// Depends on sfd_pkg.
module sfd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [7:0]    i_rx_byte,
    input  logic          i_framing_error,
    input  logic          i_q_full,
    output logic          o_in_stall,
    output logic          o_push,
    output sfd_pkg::t_op  o_op
);

    logic r_in_packet, n_in_packet;
    logic r_escape,    n_escape;
    logic accept;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        n_in_packet = r_in_packet;
        n_escape    = r_escape;
        o_push      = 1'b0;
        o_op.close  = 1'b0;
        o_op.data   = i_rx_byte;
        if (accept && !i_framing_error) begin
            if (i_rx_byte == sfd_pkg::CODE_FEND) begin
                n_escape    = 1'b0;
                n_in_packet = !r_in_packet;
                // END inside a packet closes it, even straight after ESC
                if (r_in_packet) begin
                    o_push     = 1'b1;
                    o_op.close = 1'b1;
                end
            end else if (r_in_packet) begin
                if (r_escape) begin
                    n_escape = 1'b0;
                    o_push   = 1'b1;
                    if (i_rx_byte == sfd_pkg::CODE_TFEND) begin
                        o_op.data = sfd_pkg::CODE_FEND;
                    end else if (i_rx_byte == sfd_pkg::CODE_TFESC) begin
                        o_op.data = sfd_pkg::CODE_FESC;
                    end
                end else if (i_rx_byte == sfd_pkg::CODE_FESC) begin
                    n_escape = 1'b1;
                end else begin
                    o_push = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet <= 1'b0;
            r_escape    <= 1'b0;
        end else begin
            r_in_packet <= n_in_packet;
            r_escape    <= n_escape;
        end
    end

endmodule

/* src/sfd_queue.sv */
// Small FIFO of classified ops between the front and back ends.
// Depends on sfd_pkg.
module sfd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sfd_pkg::t_op  i_op,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output sfd_pkg::t_op  o_op
);

    sfd_pkg::t_op r_mem [sfd_pkg::QDepth];

    logic [sfd_pkg::QAw-1:0] r_wr_ptr, r_rd_ptr;
    logic [sfd_pkg::QAw:0]   r_count;

    assign o_full  = (r_count == (sfd_pkg::QAw+1)'(sfd_pkg::QDepth));
    assign o_empty = (r_count == '0);
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* src/sfd_back.sv */
// Back end: counts payload, checks length and version, drives the result register.
// Depends on sfd_pkg.
module sfd_back #(
    parameter int MAX_PACKET = sfd_pkg::MaxPacketDefault
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  sfd_pkg::t_op  i_op,
    output logic          o_pop,
    input  logic [11:0]   i_max_length,
    input  logic [3:0]    i_expected_version,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [7:0]    o_out_byte,
    output logic          o_kind,
    output logic [11:0]   o_packet_length,
    output logic [1:0]    o_status
);

    localparam int CapInt = (MAX_PACKET < sfd_pkg::HardLimit) ? MAX_PACKET
                                                               : sfd_pkg::HardLimit;
    localparam logic [11:0] Cap = 12'(CapInt);

    logic [11:0] r_count, n_count;
    logic        r_ovf,   n_ovf;
    logic [3:0]  r_ver,   n_ver;
    logic        r_valid;
    logic [7:0]  r_byte,  n_byte;
    logic        r_kind,  n_kind;
    logic [11:0] r_len,   n_len;
    logic [1:0]  r_stat,  n_stat;
    logic        emit;
    logic [11:0] limit;

    assign limit = (i_max_length < Cap) ? i_max_length : Cap;
    assign o_pop = !i_q_empty && (!r_valid || !i_out_stall);

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        n_ver   = r_ver;
        n_byte  = 8'd0;
        n_kind  = sfd_pkg::KIND_DATA;
        n_len   = 12'd0;
        n_stat  = sfd_pkg::ST_OK;
        emit    = 1'b0;
        if (o_pop) begin
            if (i_op.close) begin
                emit    = 1'b1;
                n_kind  = sfd_pkg::KIND_END;
                n_len   = r_count;
                if (r_ovf) begin
                    n_stat = sfd_pkg::ST_OVERFLOW;
                end else if (r_count == 12'd0 || r_ver != i_expected_version) begin
                    n_stat = sfd_pkg::ST_INVALID;
                end
                n_count = 12'd0;
                n_ovf   = 1'b0;
            end else if (!r_ovf) begin
                if (r_count >= limit) begin
                    n_ovf = 1'b1;
                end else begin
                    emit    = 1'b1;
                    n_byte  = i_op.data;
                    n_count = r_count + 12'd1;
                    if (r_count == 12'd0) begin
                        n_ver = i_op.data[7:4];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 12'd0;
            r_ovf   <= 1'b0;
            r_ver   <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_ver   <= n_ver;
            if (emit) begin
                r_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= n_byte;
            r_kind <= n_kind;
            r_len  <= n_len;
            r_stat <= n_stat;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_out_byte      = r_byte;
    assign o_kind          = r_kind;
    assign o_packet_length = r_len;
    assign o_status        = r_stat;

endmodule

/* src/slip_frame_decoder_core.sv */
// Channel   | valid        | stall         | payload
// ----------+--------------+---------------+------------------------------------------
// input     | i_in_valid   | o_in_stall    | i_rx_byte, i_framing_error
// output    | o_out_valid  | i_out_stall   | o_out_byte, o_kind, o_packet_length, o_status
// config    | psel/penable | pready (high) | paddr, pwdata, pwrite, prdata
//
// One byte per cycle sustained while the output is not stalled; a decoded result passes
// through the queue (written at the input transfer) and then the result register.
// Input stall is the queue being full; output stall holds the result register
// and back-pressures the queue only.  Synchronous active-low reset clears all
// control state, loads the register defaults, and needs no further sweep.
//
// Top level of the SLIP deframer; depends on sfd_pkg, sfd_front, sfd_queue, sfd_back.
module slip_frame_decoder_core #(
    parameter int MAX_PACKET = sfd_pkg::MaxPacketDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_framing_error,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_kind,
    output logic [11:0] o_packet_length,
    output logic [1:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [11:0]  r_max_length;
    logic [3:0]   r_expected_version;
    logic         reg_idx;
    logic         cfg_wr;

    logic         push, pop, q_full, q_empty;
    sfd_pkg::t_op front_op, head_op;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length       <= sfd_pkg::MAX_LENGTH_RESET;
            r_expected_version <= sfd_pkg::EXP_VER_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                sfd_pkg::REG_MAX_LENGTH: r_max_length       <= pwdata[11:0];
                sfd_pkg::REG_EXP_VER:    r_expected_version <= pwdata[3:0];
                default:                 r_max_length       <= r_max_length;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            sfd_pkg::REG_MAX_LENGTH: prdata = {20'd0, r_max_length};
            sfd_pkg::REG_EXP_VER:    prdata = {28'd0, r_expected_version};
            default:                 prdata = 32'd0;
        endcase
    end

    sfd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_rx_byte       (i_rx_byte),
        .i_framing_error (i_framing_error),
        .i_q_full        (q_full),
        .o_in_stall      (o_in_stall),
        .o_push          (push),
        .o_op            (front_op)
    );

    sfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_op    (head_op)
    );

    sfd_back #(
        .MAX_PACKET (MAX_PACKET)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_empty          (q_empty),
        .i_op               (head_op),
        .o_pop              (pop),
        .i_max_length       (r_max_length),
        .i_expected_version (r_expected_version),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_byte         (o_out_byte),
        .o_kind             (o_kind),
        .o_packet_length    (o_packet_length),
        .o_status           (o_status)
    );

endmodule

/* src/sfd_checker.sv */
// Port-level checks on the SLIP deframer, bound to the top level.
// Depends on slip_frame_decoder_core's ports only.
module sfd_port_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_out_byte,
    input logic        o_kind,
    input logic [11:0] o_packet_length,
    input logic [1:0]  o_status
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_kind) && $stable(o_packet_length) && $stable(o_status))
        else $error("stalled result changed");

    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_kind |-> o_packet_length == 12'd0 && o_status == 2'd0)
        else $error("data transfer carries report fields");

    a_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind |-> o_out_byte == 8'd0 && o_status != 2'd3)
        else $error("bad end-of-packet report");

endmodule

bind slip_frame_decoder_core sfd_port_props u_sfd_port_props (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_out_byte      (o_out_byte),
    .o_kind          (o_kind),
    .o_packet_length (o_packet_length),
    .o_status        (o_status)
);
